// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the console line editor RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold on every clock outside reset.
`define ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) else $error(msg);

// Same-cycle implication.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/cle_pkg.sv =====
// Shared types and constants of the console line editor.
package cle_pkg;

    localparam int LINE_CAPACITY = 64;
    localparam int ADDR_W        = $clog2(LINE_CAPACITY);
    localparam int LEN_W         = ADDR_W + 1;

    localparam int CMD_DEPTH = 2;
    localparam int CMD_PTR_W = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
    localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);

    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic REG_RAW_MODE = 1'b0;

    localparam logic [7:0] CH_BACKSPACE = 8'h08;
    localparam logic [7:0] CH_KILL      = 8'h15;
    localparam logic [7:0] CH_NEWLINE   = 8'h0A;
    localparam logic [7:0] CH_EOT       = 8'h04;

    typedef enum logic [1:0] {
        CMD_RAW,
        CMD_LINE,
        CMD_EMPTY
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t        kind;
        logic [7:0]       ch;
        logic [LEN_W-1:0] len;
    } cmd_t;

    typedef enum logic {
        B_IDLE,
        B_LINE
    } back_state_t;

endpackage

// ===== hdl/cle_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module cle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/cle_cmd_fifo.sv =====
// Short command queue between the editing front and the delivery back.
`include "assert_macros.svh"
module cle_cmd_fifo import cle_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  cmd_t push_cmd,
    input  logic pop,
    output cmd_t head,
    output logic full,
    output logic empty
);

    cmd_t                 entry_reg [CMD_DEPTH];
    logic [CMD_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CMD_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CMD_CNT_W-1:0] count_reg, count_next;

    function automatic logic [CMD_PTR_W-1:0] ptr_inc(input logic [CMD_PTR_W-1:0] p);
        return (p == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_comb begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop  ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg + CMD_CNT_W'(push) - CMD_CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    assign head  = entry_reg[rd_ptr_reg];
    assign full  = (count_reg == CMD_CNT_W'(CMD_DEPTH));
    assign empty = (count_reg == '0);

    `ASSERT_IMPLIES(a_fifo_no_overflow, push, !full, "command pushed into full queue")

endmodule

// ===== hdl/cle_front.sv =====
// Front end: accepts keyboard bytes, edits the line, queues delivery commands.
`include "assert_macros.svh"
module cle_front import cle_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              raw_mode,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [7:0]        s_in_char,
    input  logic              fifo_full,
    output logic              push,
    output cmd_t              push_cmd,
    output logic              ram_we,
    output logic [ADDR_W-1:0] ram_waddr,
    output logic [7:0]        ram_wdata,
    input  logic              line_done
);

    logic [ADDR_W-1:0] fill_reg, fill_next;
    logic              busy_reg, busy_next;
    logic              accept;
    logic [LEN_W-1:0]  cnt_inc;

    assign s_ready   = !busy_reg && !fifo_full;
    assign accept    = s_valid && s_ready;
    assign cnt_inc   = {1'b0, fill_reg} + 1'b1;
    assign ram_waddr = fill_reg;
    assign ram_wdata = s_in_char;

    always_comb begin
        fill_next     = fill_reg;
        busy_next     = busy_reg && !line_done;
        push          = 1'b0;
        push_cmd.kind = CMD_RAW;
        push_cmd.ch   = s_in_char;
        push_cmd.len  = cnt_inc;
        ram_we        = 1'b0;
        if (accept) begin
            if (raw_mode) begin
                push = 1'b1;
            end else begin
                unique case (s_in_char)
                    CH_BACKSPACE: begin
                        if (fill_reg != '0) begin
                            fill_next = fill_reg - 1'b1;
                        end
                    end
                    CH_KILL: begin
                        fill_next = '0;
                    end
                    CH_EOT: begin
                        push         = 1'b1;
                        fill_next    = '0;
                        push_cmd.len = {1'b0, fill_reg};
                        if (fill_reg == '0) begin
                            push_cmd.kind = CMD_EMPTY;
                        end else begin
                            push_cmd.kind = CMD_LINE;
                            busy_next     = 1'b1;
                        end
                    end
                    CH_NEWLINE: begin
                        ram_we        = 1'b1;
                        push          = 1'b1;
                        push_cmd.kind = CMD_LINE;
                        fill_next     = '0;
                        busy_next     = 1'b1;
                    end
                    default: begin
                        ram_we = 1'b1;
                        if (cnt_inc == LEN_W'(LINE_CAPACITY)) begin
                            push          = 1'b1;
                            push_cmd.kind = CMD_LINE;
                            fill_next     = '0;
                            busy_next     = 1'b1;
                        end else begin
                            fill_next = cnt_inc[ADDR_W-1:0];
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
            busy_reg <= 1'b0;
        end else begin
            fill_reg <= fill_next;
            busy_reg <= busy_next;
        end
    end

    `ASSERT_NEXT(a_line_sets_busy, push && push_cmd.kind == CMD_LINE, busy_reg && fill_reg == '0,
        "queued line did not lock the line store")

endmodule

// ===== hdl/cle_back.sv =====
// Back end: executes queued commands, reads lines out of the store.
`include "assert_macros.svh"
module cle_back import cle_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              fifo_empty,
    input  cmd_t              head,
    output logic              pop,
    output logic              ram_re,
    output logic [ADDR_W-1:0] ram_raddr,
    input  logic [7:0]        ram_rdata,
    output logic              line_done,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [7:0]        m_out_char,
    output logic              m_line_end,
    output logic              m_empty_line
);

    back_state_t       state_reg, state_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [ADDR_W-1:0] idx_reg, idx_next;
    logic              rd_pend_reg, rd_pend_next;
    logic              out_valid_reg, out_valid_next;
    logic [7:0]        out_char_reg, out_char_next;
    logic              out_end_reg, out_end_next;
    logic              out_empty_reg, out_empty_next;
    logic              slot_free;
    logic              last;
    logic              load_line;

    assign slot_free = !out_valid_reg || m_ready;
    assign last      = (({1'b0, idx_reg} + 1'b1) == len_reg);

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE: begin
                if (!fifo_empty && slot_free && head.kind == CMD_LINE) begin
                    state_next = B_LINE;
                end
            end
            B_LINE: begin
                if (rd_pend_reg && slot_free && last) begin
                    state_next = B_IDLE;
                end
            end
        endcase
    end

    // outputs and datapath
    always_comb begin
        pop            = (state_reg == B_IDLE) && !fifo_empty && slot_free;
        ram_re         = (state_reg == B_LINE) && !rd_pend_reg;
        load_line      = (state_reg == B_LINE) && rd_pend_reg && slot_free;
        line_done      = load_line && last;
        len_next       = len_reg;
        idx_next       = idx_reg;
        rd_pend_next   = rd_pend_reg;
        out_valid_next = out_valid_reg && !m_ready;
        out_char_next  = out_char_reg;
        out_end_next   = out_end_reg;
        out_empty_next = out_empty_reg;
        if (ram_re) begin
            rd_pend_next = 1'b1;
        end
        if (pop) begin
            unique case (head.kind)
                CMD_RAW: begin
                    out_valid_next = 1'b1;
                    out_char_next  = head.ch;
                    out_end_next   = 1'b1;
                    out_empty_next = 1'b0;
                end
                CMD_EMPTY: begin
                    out_valid_next = 1'b1;
                    out_char_next  = '0;
                    out_end_next   = 1'b1;
                    out_empty_next = 1'b1;
                end
                CMD_LINE: begin
                    len_next = head.len;
                    idx_next = '0;
                end
                default: begin
                end
            endcase
        end
        if (load_line) begin
            rd_pend_next   = 1'b0;
            idx_next       = idx_reg + 1'b1;
            out_valid_next = 1'b1;
            out_char_next  = ram_rdata;
            out_end_next   = last;
            out_empty_next = 1'b0;
        end
    end

    assign ram_raddr = idx_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= B_IDLE;
            rd_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            rd_pend_reg   <= rd_pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        len_reg       <= len_next;
        idx_reg       <= idx_next;
        out_char_reg  <= out_char_next;
        out_end_reg   <= out_end_next;
        out_empty_reg <= out_empty_next;
    end

    assign m_valid      = out_valid_reg;
    assign m_out_char   = out_char_reg;
    assign m_line_end   = out_end_reg;
    assign m_empty_line = out_empty_reg;

    `ASSERT_IMPLIES(a_pend_in_line, rd_pend_reg, state_reg == B_LINE,
        "store read pending outside line readout")
    `ASSERT_NEXT(a_done_marks_end, line_done, state_reg == B_IDLE && m_valid && m_line_end,
        "line readout finished without marked last byte")

endmodule

// ===== hdl/console_line_editor_top.sv =====
// Top level of the console line editor: APB register, front, queue, store, back.
// A raw byte passes the command queue and the output register before it shows on m_. A
// line's first byte passes the queue, the back's line state, the store read and the output
// register; each further byte takes a store read and a load. Throughput: 1 input transfer
// per cycle while a line is edited and the command queue is not full; input stalls while
// a finished line is read out of the line store. Reset (aresetn low, synchronous) clears
// raw_mode, fill count, queue and output register, not the line store, which needs none.
`include "assert_macros.svh"
module console_line_editor_top import cle_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    // APB configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    // keyboard byte input
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [7:0]         s_in_char,
    // delivered line bytes
    output logic               m_valid,
    input  logic               m_ready,
    output logic [7:0]         m_out_char,
    output logic               m_line_end,
    output logic               m_empty_line
);

    logic raw_mode_reg, raw_mode_next;
    logic reg_sel;

    // Front to queue
    logic push;
    cmd_t push_cmd;
    logic fifo_full;
    // Queue to back
    logic pop;
    cmd_t head;
    logic fifo_empty;
    // Line store ports
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [7:0]        ram_wdata;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    logic [7:0]        ram_rdata;
    // Back releases the store once the last byte of a line has been read
    logic line_done;

    // Register index sits above the byte offset bits.
    assign reg_sel = (paddr[PADDR_W-1:2] == REG_RAW_MODE);
    assign pready  = 1'b1;
    assign prdata  = reg_sel ? {{(PDATA_W-1){1'b0}}, raw_mode_reg} : '0;

    always_comb begin
        raw_mode_next = raw_mode_reg;
        if (psel && penable && pwrite && reg_sel) begin
            raw_mode_next = pwdata[0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            raw_mode_reg <= 1'b0;
        end else begin
            raw_mode_reg <= raw_mode_next;
        end
    end

    // Editing front end: classifies each byte, updates the fill count,
    // writes the store and queues raw / line / empty-line commands.
    cle_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .raw_mode  (raw_mode_reg),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_in_char (s_in_char),
        .fifo_full (fifo_full),
        .push      (push),
        .push_cmd  (push_cmd),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .line_done (line_done)
    );

    // Decouples the front from the output side.
    cle_cmd_fifo u_cmd_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .full     (fifo_full),
        .empty    (fifo_empty)
    );

    // Line store: written by the front, read by the back.
    cle_ram #(
        .WIDTH (8),
        .DEPTH (LINE_CAPACITY)
    ) u_line_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Delivery back end with its own output register.
    cle_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .fifo_empty   (fifo_empty),
        .head         (head),
        .pop          (pop),
        .ram_re       (ram_re),
        .ram_raddr    (ram_raddr),
        .ram_rdata    (ram_rdata),
        .line_done    (line_done),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_char   (m_out_char),
        .m_line_end   (m_line_end),
        .m_empty_line (m_empty_line)
    );

    // The store must not be written while the back may still read a line from it.
    `ASSERT_IMPLIES(a_no_write_during_read, ram_we, !ram_re,
        "line store written during line readout")

endmodule
